// ===== rtl/bitmap_text_glyph_renderer_top_assert.svh =====
// Assertion macros for the glyph renderer checker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef BITMAP_TEXT_GLYPH_RENDERER_TOP_ASSERT_SVH
`define BITMAP_TEXT_GLYPH_RENDERER_TOP_ASSERT_SVH

// Clocked check, switched off while reset is asserted.
`define BTGR_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BTGR_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/btgr_pkg.sv =====
// Shared types, codes and helper functions for the bitmap text glyph renderer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package btgr_pkg;

	typedef enum logic [1:0] {
		OP_PRINT    = 2'd0,
		OP_CURSOR   = 2'd1,
		OP_GLYPH_WR = 2'd2,
		OP_MAP_WR   = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MAP  = 5'b00010,
		ST_GLY0 = 5'b00100,
		ST_GLY1 = 5'b01000,
		ST_SCAN = 5'b10000
	} state_t;

	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SIZE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_SPACING = 1'd1;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] COUNT_MAX    = 8'hFF;
	localparam int unsigned MAP_DEPTH   = 256;
	localparam int unsigned MAP_IN_W    = 7;

	// Saturating increment of a column or line count.
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
	endfunction

	// Reorders a glyph word into scan order: column major, row minor.
	// Position c*4+r takes bit 24+c-8r of the word.
	function automatic logic [31:0] scan_order(input logic [31:0] w);
		logic [31:0] res;
		res = '0;
		for (int c = 0; c < 8; c++) begin
			for (int r = 0; r < 4; r++) begin
				res[c*4 + r] = w[24 + c - 8*r];
			end
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bitmap_text_glyph_renderer_top.sv =====
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   operation, char_code, pos_x, pos_y, table_*
// out       source     out_valid/out_stall box_x, box_y, clipped, last
// cfg       sink       cfg_wr_en           cfg_index, cfg_data
//
// Table writes, cursor loads and newlines complete without stalling the input.
// A printed character holds in_stall high after its transfer while the map read, the two
// glyph store reads (with two words per glyph) and the one-bit-per-cycle scan of the glyph
// words run; the scan stops after the last set bit, pauses while a set bit waits on a
// stalled output, and ends at once for an empty glyph.
// Reset is asynchronous; it clears the cursor, counts and handshake state and sets the
// font size to 1 and the spacing to 8. Both tables are undefined until software writes them.
// A stalled output holds its box; the scan waits on it and resumes when it leaves.
`default_nettype none

module bitmap_text_glyph_renderer_top
	import btgr_pkg::*;
#(
	parameter int unsigned GLYPH_COUNT     = 128,
	parameter int unsigned WORDS_PER_GLYPH = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic [1:0]           operation,
	input  wire logic [7:0]           char_code,
	input  wire logic [15:0]          pos_x,
	input  wire logic [15:0]          pos_y,
	input  wire logic [7:0]           table_index,
	input  wire logic [31:0]          table_word,

	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [15:0]          box_x,
	output      logic [15:0]          box_y,
	output      logic                 clipped,
	output      logic                 last,

	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [3:0]           cfg_data
);

	// Glyph store depth and the widths that follow from the parameters.
	localparam int unsigned SD  = GLYPH_COUNT * WORDS_PER_GLYPH;
	localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;
	localparam int unsigned GW  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
	localparam int unsigned NB  = 32 * WORDS_PER_GLYPH;
	localparam int unsigned PW  = $clog2(NB);

	// The two tables. Each has one write port used only while idle and one
	// registered read port used only while printing, so the accesses never
	// overlap and need no forwarding.
	logic [31:0]    glyph_mem [SD];
	logic [GW-1:0]  map_mem   [MAP_DEPTH];
	logic [31:0]    glyph_rd_q;
	logic [GW-1:0]  map_rd_q;

	// Map entries are reduced modulo the glyph count when written, through a
	// constant table indexed by the low seven bits of the written word.
	logic [GW-1:0]  mod_tab [2**MAP_IN_W];
	for (genvar gi = 0; gi < 2**MAP_IN_W; gi++) begin : g_mod
		assign mod_tab[gi] = GW'(gi % GLYPH_COUNT);
	end

	// Control state.
	state_t         state_q;
	logic           out_valid_q;
	logic [15:0]    cursor_x_q;
	logic [15:0]    cursor_y_q;
	logic [7:0]     col_q;
	logic [7:0]     line_q;
	logic [3:0]     size_q;
	logic [3:0]     spacing_q;

	// Per-character working registers.
	logic [7:0]     pitch_q;
	logic [15:0]    colmul_q;
	logic [15:0]    linmul_q;
	logic [SAW-1:0] gbase_q;
	logic [17:0]    bx_q;
	logic [17:0]    by_q;
	logic [NB-1:0]  seq_q;
	logic [PW-1:0]  pos_q;

	// Output register.
	logic [15:0]    box_x_q;
	logic [15:0]    box_y_q;
	logic           clipped_q;
	logic           last_q;

	op_t            op;
	logic           in_xfer;
	logic           is_char;
	logic           glyph_wr_ok;
	logic [SAW-1:0] map_base;
	logic [SAW-1:0] glyph_raddr;
	logic           glyph_rd_en;
	logic           out_free;
	logic           emit;
	logic           advance;
	logic           last_bit;
	logic           wsel;
	logic [2:0]     row_idx;
	logic [2:0]     col_idx;
	logic [6:0]     xoff;
	logic [6:0]     yoff;
	logic [17:0]    x_full;
	logic [17:0]    y_full;

	assign op          = op_t'(operation);
	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign is_char     = (op == OP_PRINT) && (char_code != NEWLINE_CODE);
	assign glyph_wr_ok = ({1'b0, table_index} < 9'(SD));

	assign map_base    = SAW'(map_rd_q * WORDS_PER_GLYPH);
	assign glyph_raddr = (state_q == ST_GLY0) ? (gbase_q + SAW'(1)) : map_base;
	assign glyph_rd_en = (state_q == ST_MAP)
		|| ((state_q == ST_GLY0) && (WORDS_PER_GLYPH > 1));

	// The scan walks one glyph bit per cycle; a set bit waits until the
	// output register can take its box.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = (state_q == ST_SCAN) && (seq_q != '0) && (!seq_q[0] || out_free);
	assign emit     = advance && seq_q[0];
	assign last_bit = ((seq_q >> 1) == '0);

	// Scan position: row fastest, then column, then word.
	assign wsel    = (WORDS_PER_GLYPH > 1) ? pos_q[PW-1] : 1'b0;
	assign row_idx = {wsel, pos_q[1:0]};
	assign col_idx = pos_q[4:2];
	assign xoff    = {4'b0, col_idx} * {3'b0, size_q};
	assign yoff    = {4'b0, row_idx} * {3'b0, size_q};
	assign x_full  = bx_q + {11'b0, xoff};
	assign y_full  = by_q + {11'b0, yoff};

	// Table memories.
	always_ff @(posedge clk) begin
		if (in_xfer && (op == OP_GLYPH_WR) && glyph_wr_ok) begin
			glyph_mem[table_index[SAW-1:0]] <= table_word;
		end
		if (in_xfer && (op == OP_MAP_WR)) begin
			map_mem[table_index] <= mod_tab[table_word[MAP_IN_W-1:0]];
		end
		if (in_xfer && is_char) begin
			map_rd_q <= map_mem[char_code];
		end
		if (glyph_rd_en) begin
			glyph_rd_q <= glyph_mem[glyph_raddr];
		end
	end

	// Control state, counts, cursor and font registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
			col_q       <= '0;
			line_q      <= '0;
			size_q      <= 4'd1;
			spacing_q   <= 4'd8;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_FONT_SIZE) begin
					size_q <= cfg_data;
				end else begin
					spacing_q <= cfg_data;
				end
			end

			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						unique case (op)
							OP_PRINT: begin
								if (char_code == NEWLINE_CODE) begin
									col_q  <= '0;
									line_q <= sat_inc(line_q);
								end else begin
									state_q <= ST_MAP;
								end
							end
							OP_CURSOR: begin
								cursor_x_q <= pos_x;
								cursor_y_q <= pos_y;
								col_q      <= '0;
								line_q     <= '0;
							end
							OP_GLYPH_WR, OP_MAP_WR: begin
							end
						endcase
					end
				end
				ST_MAP: begin
					// The offset multiply has already sampled the old column.
					col_q   <= sat_inc(col_q);
					state_q <= ST_GLY0;
				end
				ST_GLY0: begin
					state_q <= (WORDS_PER_GLYPH > 1) ? ST_GLY1 : ST_SCAN;
				end
				ST_GLY1: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if ((seq_q == '0) || (emit && last_bit)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: cell origin arithmetic, scan vector and output box.
	always_ff @(posedge clk) begin
		pitch_q <= {4'b0, size_q} * {4'b0, spacing_q};

		if (state_q == ST_MAP) begin
			colmul_q <= {8'b0, pitch_q} * {8'b0, col_q};
			linmul_q <= {8'b0, pitch_q} * {8'b0, line_q};
			gbase_q  <= map_base;
		end

		if (state_q == ST_GLY0) begin
			bx_q  <= {2'b0, cursor_x_q} + {2'b0, colmul_q};
			by_q  <= {2'b0, cursor_y_q} + {1'b0, linmul_q, 1'b0};
			seq_q <= NB'(scan_order(glyph_rd_q));
			pos_q <= '0;
		end else if (state_q == ST_GLY1) begin
			seq_q <= seq_q | (NB'(scan_order(glyph_rd_q)) << 32);
		end else if (advance) begin
			seq_q <= seq_q >> 1;
			pos_q <= pos_q + PW'(1);
		end

		if (emit) begin
			box_x_q   <= x_full[15:0];
			box_y_q   <= y_full[15:0];
			clipped_q <= (x_full[17:16] != 2'b0) || (y_full[17:16] != 2'b0);
			last_q    <= last_bit;
		end
	end

	assign out_valid = out_valid_q;
	assign box_x     = box_x_q;
	assign box_y     = box_y_q;
	assign clipped   = clipped_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== rtl/btgr_checker.sv =====
// Port-level checker for the glyph renderer, bound to the top level.
// Depends on btgr_pkg and the assertion macro header.
`default_nettype none
`include "bitmap_text_glyph_renderer_top_assert.svh"

module btgr_checker
	import btgr_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  operation,
	input wire logic [7:0]  char_code,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] box_x,
	input wire logic [15:0] box_y,
	input wire logic        clipped,
	input wire logic        last
);

	logic        in_xfer;
	logic        char_xfer;
	logic [33:0] box_bits;

	assign in_xfer   = in_valid && !in_stall;
	assign char_xfer = in_xfer && (operation == OP_PRINT) && (char_code != NEWLINE_CODE);
	assign box_bits  = {box_x, box_y, clipped, last};

	// A clock edge seen in reset leaves the block ready and with no box pending.
	`BTGR_ASSERT_RST(a_reset_quiet, !arst_n |=> (!out_valid && !in_stall), "busy in reset")

	// A printable character keeps the input stalled while it is worked on.
	`BTGR_ASSERT_CLK(a_print_busy, char_xfer |=> in_stall, "print did not stall input")

	// Every other transfer leaves the input unstalled.
	`BTGR_ASSERT_CLK(a_single_cycle, (in_xfer && !char_xfer) |=> !in_stall, "op stalled")

	// A stalled box stays put.
	`BTGR_ASSERT_CLK(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(box_bits)), "stalled box changed")

endmodule

bind bitmap_text_glyph_renderer_top btgr_checker u_btgr_checker (.*);

`default_nettype wire

// ===== test/bitmap_text_glyph_renderer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_text_glyph_renderer_top: a scoreboard class predicts
// every box origin, and plain tasks drive the input, output and register ports.
// Depends on btgr_pkg and the top level RTL only.

class box_scoreboard;
	localparam int unsigned GLYPHS      = 128;
	localparam int unsigned GLYPH_WORDS = 2;
	localparam int unsigned SHOWN_MAX   = 50;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        clipped;
		logic        last;
	} box_t;

	logic [3:0]  scale;
	logic [3:0]  spacing;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	logic [7:0]  col;
	logic [7:0]  line;
	logic [31:0] glyph_words [256];
	logic [6:0]  char_glyph [256];
	box_t        expected_boxes [$];
	int unsigned mismatches;

	function new();
		scale = 4'd1;
		spacing = 4'd8;
		cur_x = '0;
		cur_y = '0;
		col = '0;
		line = '0;
		mismatches = 0;
		foreach (glyph_words[i]) glyph_words[i] = '0;
		foreach (char_glyph[i]) char_glyph[i] = '0;
	endfunction

	function void set_register(logic [btgr_pkg::CFG_IDX_W-1:0] idx, logic [3:0] value);
		if (idx == btgr_pkg::REG_FONT_SIZE)
			scale = value;
		else if (idx == btgr_pkg::REG_FONT_SPACING)
			spacing = value;
	endfunction

	function int unsigned pending();
		return expected_boxes.size();
	endfunction

	function logic [7:0] bump(logic [7:0] v);
		return (v == btgr_pkg::COUNT_MAX) ? v : v + 8'd1;
	endfunction

	// Queues one box per set glyph bit: word, then column, then row.
	function void expect_glyph(logic [7:0] ch);
		int unsigned pitch, bx, by, x, y, total, n, g;
		logic [7:0]  addr;
		logic [31:0] word;
		box_t b;
		pitch = scale * spacing;
		bx = cur_x + pitch * col;
		by = cur_y + 2 * pitch * line;
		g = char_glyph[ch] % GLYPHS;
		total = 0;
		n = 0;
		for (int w = 0; w < GLYPH_WORDS; w++) begin
			addr = 8'(g * GLYPH_WORDS + w);
			total += $countones(glyph_words[addr]);
		end
		for (int w = 0; w < GLYPH_WORDS; w++) begin
			addr = 8'(g * GLYPH_WORDS + w);
			word = glyph_words[addr];
			for (int c = 0; c < 8; c++) begin
				for (int r = 0; r < 4; r++) begin
					if (word[24 + c - 8 * r]) begin
						x = bx + c * scale;
						y = by + (4 * w + r) * scale;
						b.x = x[15:0];
						b.y = y[15:0];
						b.clipped = (x > 32'hFFFF) || (y > 32'hFFFF);
						b.last = (n == total - 1);
						expected_boxes.push_back(b);
						n++;
					end
				end
			end
		end
		col = bump(col);
	endfunction

	function void note_input(btgr_pkg::op_t op, logic [7:0] ch, logic [15:0] px,
			logic [15:0] py, logic [7:0] idx, logic [31:0] word);
		case (op)
			btgr_pkg::OP_PRINT: begin
				if (ch == btgr_pkg::NEWLINE_CODE) begin
					col = '0;
					line = bump(line);
				end else begin
					expect_glyph(ch);
				end
			end
			btgr_pkg::OP_CURSOR: begin
				cur_x = px;
				cur_y = py;
				col = '0;
				line = '0;
			end
			btgr_pkg::OP_GLYPH_WR: begin
				if (idx < GLYPHS * GLYPH_WORDS)
					glyph_words[idx] = word;
			end
			default: char_glyph[idx] = word[6:0];
		endcase
	endfunction

	task report(string what);
		if (mismatches < SHOWN_MAX)
			$display("MISMATCH: %s", what);
		mismatches++;
	endtask

	task check_box(logic [15:0] x, logic [15:0] y, logic clip, logic fin);
		box_t want;
		if (expected_boxes.size() == 0) begin
			report($sformatf("box (%0d,%0d) with nothing expected", x, y));
		end else begin
			want = expected_boxes.pop_front();
			if (x !== want.x)
				report($sformatf("box_x %0d, expected %0d", x, want.x));
			if (y !== want.y)
				report($sformatf("box_y %0d, expected %0d", y, want.y));
			if (clip !== want.clipped)
				report($sformatf("clipped %b, expected %b at (%0d,%0d)", clip, want.clipped,
					want.x, want.y));
			if (fin !== want.last)
				report($sformatf("last %b, expected %b at (%0d,%0d)", fin, want.last,
					want.x, want.y));
		end
	endtask
endclass

module testbench;
	import btgr_pkg::*;

	// The run ends here only if the block hangs; a correct run needs a small fraction of it.
	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	// A boxless character keeps the block busy through its map read, glyph reads and an empty
	// scan after its transfer; one with boxes also scans its glyph bits and waits out output stalls.
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned RANDOM_CHUNKS = 5;
	localparam int unsigned CHUNK_ITEMS   = 12;

	// Fixed characters and glyphs used by the directed part.
	localparam logic [7:0] FULL_CHAR    = 8'd0;
	localparam logic [7:0] EMPTY_CHAR   = 8'd32;
	localparam logic [7:0] ALT_CHAR     = 8'd65;
	localparam logic [7:0] SPARSE_CHAR  = 8'd255;
	localparam logic [6:0] FULL_GLYPH   = 7'd0;
	localparam logic [6:0] EMPTY_GLYPH  = 7'd1;
	localparam logic [6:0] SPARSE_GLYPH = 7'd127;

	typedef enum logic [1:0] {
		RX_FLOW,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	// Every block input starts at a known value.
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic [1:0]           operation = '0;
	logic [7:0]           char_code = '0;
	logic [15:0]          pos_x = '0;
	logic [15:0]          pos_y = '0;
	logic [7:0]           table_index = '0;
	logic [31:0]          table_word = '0;
	logic                 out_stall = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [3:0]           cfg_data = '0;

	logic        in_stall;
	logic        out_valid;
	logic [15:0] box_x;
	logic [15:0] box_y;
	logic        clipped;
	logic        last;

	box_scoreboard boxes = new();

	// Stimulus-side knowledge of which table entries hold data, so that no print ever
	// reads an entry that software has not written.
	bit          map_known [256];
	logic [6:0]  map_target [256];
	bit          word_known [256];
	logic [7:0]  mapped_chars [$];
	logic [6:0]  loaded_glyphs [$];

	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          hold_outputs = 1'b0;
	int unsigned cycle_count = 0;

	bitmap_text_glyph_renderer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.char_code  (char_code),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.table_index(table_index),
		.table_word (table_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.box_x      (box_x),
		.box_y      (box_y),
		.clipped    (clipped),
		.last       (last),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge. Every input transfer updates the
	// prediction, and every output transfer is checked against the oldest expected box.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			boxes.note_input(op_t'(operation), char_code, pos_x, pos_y, table_index, table_word);
		if (arst_n && out_valid && !out_stall)
			boxes.check_box(box_x, box_y, clipped, last);
	end

	// The receiver switches between free flow, random stalls and a repeating mask, each for
	// a random stretch. On request it holds off for a long stretch so that the block fills
	// up and has to stall its input.
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned span;
		int unsigned hold_left;
		int unsigned tick;
		logic [7:0]  mask;
		mode = RX_FLOW;
		span = 0;
		hold_left = 0;
		tick = 0;
		mask = '0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_outputs) begin
				hold_outputs = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					span = $urandom_range(16, 160);
					mask = 8'($urandom);
				end
				span--;
				case (mode)
					RX_FLOW: out_stall <= 1'b0;
					RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= mask[tick[2:0]];
				endcase
			end
		end
	end

	// Offers one item and returns at the falling edge after its transfer. Items go out in
	// bursts of random length; a random gap comes before each burst unless gaps are off.
	// The payload only changes after a transfer, and valid stays high inside a burst.
	task automatic offer_item(op_t op, logic [7:0] ch, logic [15:0] px, logic [15:0] py,
			logic [7:0] idx, logic [31:0] word);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = gaps_on ? $urandom_range(1, 8) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		operation <= op;
		char_code <= ch;
		pos_x <= px;
		pos_y <= py;
		table_index <= idx;
		table_word <= word;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Unused fields carry random values so that every input bit sees both levels.
	task automatic print_char(logic [7:0] ch);
		offer_item(OP_PRINT, ch, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic move_cursor(logic [15:0] x, logic [15:0] y);
		offer_item(OP_CURSOR, 8'($urandom), x, y, 8'($urandom), $urandom);
	endtask

	task automatic write_word(logic [7:0] idx, logic [31:0] word);
		offer_item(OP_GLYPH_WR, 8'($urandom), 16'($urandom), 16'($urandom), idx, word);
		word_known[idx] = 1'b1;
	endtask

	task automatic write_map(logic [7:0] ch, logic [31:0] word);
		offer_item(OP_MAP_WR, 8'($urandom), 16'($urandom), 16'($urandom), ch, word);
		if (!map_known[ch])
			mapped_chars.push_back(ch);
		map_known[ch] = 1'b1;
		map_target[ch] = word[6:0];
	endtask

	// A character may be printed once its map entry and both words of its glyph exist.
	function automatic bit can_print(logic [7:0] ch);
		logic [6:0] g;
		if (ch == NEWLINE_CODE)
			return 1'b1;
		g = map_target[ch];
		return map_known[ch] && word_known[{g, 1'b0}] && word_known[{g, 1'b1}];
	endfunction

	// Glyph words of mixed density: mostly sparse, with blank and solid ones too.
	function automatic logic [31:0] glyph_bits();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1, 2: return $urandom & $urandom;
			3: return $urandom & $urandom & $urandom;
			4: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic load_glyph(logic [6:0] g);
		write_word({g, 1'b0}, glyph_bits());
		write_word({g, 1'b1}, glyph_bits());
		loaded_glyphs.push_back(g);
	endtask

	// Lowers valid and waits for every expected box, then for the longest time a last
	// boxless character could still keep the block busy.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (boxes.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both font registers on consecutive cycles; only called while the block idles.
	task automatic set_font(logic [3:0] scale, logic [3:0] spacing);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FONT_SIZE;
		cfg_data <= scale;
		@(negedge clk);
		cfg_index <= REG_FONT_SPACING;
		cfg_data <= spacing;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		boxes.set_register(REG_FONT_SIZE, scale);
		boxes.set_register(REG_FONT_SPACING, spacing);
	endtask

	// Mostly prints of characters that are ready, with newlines, cursor moves and table
	// rewrites mixed in. Map writes usually point at a loaded glyph.
	task automatic random_item();
		int unsigned pick;
		logic [7:0]  ch;
		bit          found;
		logic [31:0] word;
		pick = $urandom_range(0, 99);
		found = 1'b0;
		ch = NEWLINE_CODE;
		if (pick < 55) begin
			for (int t = 0; t < 16 && !found; t++) begin
				ch = mapped_chars[$urandom_range(0, mapped_chars.size() - 1)];
				found = can_print(ch);
			end
			print_char(found ? ch : NEWLINE_CODE);
		end else if (pick < 63) begin
			print_char(NEWLINE_CODE);
		end else if (pick < 72) begin
			move_cursor(16'($urandom), 16'($urandom));
		end else if (pick < 86) begin
			write_word(8'($urandom_range(0, 255)), glyph_bits());
		end else begin
			word = $urandom;
			if (loaded_glyphs.size() != 0 && $urandom_range(0, 3) != 0)
				word[6:0] = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
			write_map(8'($urandom_range(0, 255)), word);
		end
	endtask

	initial begin : stimulus
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset font: a solid glyph (the most boxes one character can
		// give), a blank glyph and a sparse one at the top glyph number. Map values carry
		// upper bits that the block must drop.
		write_word({FULL_GLYPH, 1'b0}, 32'hFFFF_FFFF);
		write_word({FULL_GLYPH, 1'b1}, 32'hFFFF_FFFF);
		write_word({EMPTY_GLYPH, 1'b0}, 32'h0000_0000);
		write_word({EMPTY_GLYPH, 1'b1}, 32'h0000_0000);
		write_word({SPARSE_GLYPH, 1'b0}, 32'h8000_0001);
		write_word({SPARSE_GLYPH, 1'b1}, 32'h1248_8421);
		write_map(FULL_CHAR, {25'h0000001, FULL_GLYPH});
		write_map(SPARSE_CHAR, 32'hFFFF_FFFF);
		write_map(EMPTY_CHAR, {25'h1FFFFFE, EMPTY_GLYPH});
		write_map(ALT_CHAR, {25'h0000002, FULL_GLYPH});
		print_char(FULL_CHAR);
		print_char(SPARSE_CHAR);
		// A blank glyph gives no boxes but still moves the column on.
		print_char(EMPTY_CHAR);
		print_char(NEWLINE_CODE);
		print_char(ALT_CHAR);
		// Near the top of the coordinate range the boxes wrap and are flagged.
		move_cursor(16'hFFFF, 16'hFFFF);
		print_char(SPARSE_CHAR);
		print_char(FULL_CHAR);
		print_char(NEWLINE_CODE);
		print_char(EMPTY_CHAR);
		move_cursor(16'h0000, 16'h0000);
		print_char(SPARSE_CHAR);
		drain_and_settle();

		// Largest font near the top of the range: the widest cell and line offsets push
		// both coordinates past 16 bits.
		set_font(4'd15, 4'd15);
		move_cursor(16'hFF00, 16'hFF00);
		print_char(EMPTY_CHAR);
		print_char(SPARSE_CHAR);
		print_char(FULL_CHAR);
		print_char(NEWLINE_CODE);
		print_char(FULL_CHAR);
		drain_and_settle();

		// Zero size and spacing are taken as they are: every box lands on the cursor.
		set_font(4'd0, 4'd0);
		move_cursor(16'($urandom), 16'($urandom));
		print_char(FULL_CHAR);
		print_char(SPARSE_CHAR);
		print_char(NEWLINE_CODE);
		print_char(SPARSE_CHAR);
		drain_and_settle();

		// Tables for the random part: a handful of glyphs and characters across the whole
		// code range.
		repeat (10) load_glyph(7'($urandom_range(0, 127)));
		repeat (16)
			write_map(8'($urandom_range(0, 255)),
				{$urandom_range(0, 1) == 0 ? 25'h0 : 25'($urandom),
				 loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)]});

		// Random part in chunks, each at its own font setting with the block idle around
		// the register writes. The second chunk starts with a long receiver hold-off; the
		// third sends back to back with no gaps.
		for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
			drain_and_settle();
			case (chunk)
				0: set_font(4'd1, 4'd1);
				1: set_font(4'd15, 4'd1);
				2: set_font(4'd1, 4'd15);
				default: set_font(4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)));
			endcase
			gaps_on = (chunk != 2);
			if (chunk == 1)
				hold_outputs = 1'b1;
			repeat (CHUNK_ITEMS) random_item();
		end

		drain_and_settle();
		if (boxes.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/btgr_pkg.sv
rtl/bitmap_text_glyph_renderer_top.sv
rtl/btgr_checker.sv
test/bitmap_text_glyph_renderer_tb.sv
